>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the checker files.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, gated by the active-low reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, gated by the active-low reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> hw/rtl/f2p24_pkg.sv
// Shared constants and stage types of the float to packed 24-bit converter.
// Used by f2p24_mask and float_to_packed24_float.
package f2p24_pkg;
	localparam int FRAC_W = 43;
	localparam int INT_W = 23;
	localparam int WIDE_W = FRAC_W + INT_W;
	localparam int POS_W = 7;
	localparam logic [23:0] TINY_THR = 24'd8796093;
	localparam logic [7:0] BEXP_SPEC = 8'd255;
	localparam logic [7:0] BEXP_BIG = 8'd150;
	localparam logic [7:0] BEXP_MIN = 8'd107;
	localparam logic [7:0] BEXP_BIAS = 8'd126;
	localparam logic [7:0] EXP_LIMIT = 8'd63;
	localparam logic [6:0] EXP_MAX = 7'd63;
	localparam logic [15:0] FRAC_ONES = 16'hffff;
	localparam logic [6:0] EXP_OFFS = 7'd86;
	localparam logic [6:0] POS_TOP = 7'd65;

	typedef struct packed {
		logic spec;
		logic [23:0] spec_word;
		logic sat;
		logic sign;
		logic [WIDE_W-1:0] wide;
	} stage_t;
endpackage

>>> hw/rtl/float_to_packed24_float.sv
// Top level of the float to packed 24-bit converter, four-stage pipeline.
// Depends on f2p24_pkg and f2p24_mask.
//
// Usage:
//   Input channel s_*: one IEEE-754 single bit pattern per transfer on
//   s_tdata. Output channel m_*: the packed word on m_tdata (sign bit 23,
//   two's-complement exponent bits 22..16, fraction bits 15..0) and the
//   saturation flag on m_tuser.
//   Each result passes the stage registers s1, s2, s3 and s4 and is
//   offered on m_* from s4 until the receiver takes it.
//   Throughput is one item per cycle while the receiver does not stall.
//   Stage 1 decodes special classes and aligns the mantissa into a fixed
//   point word, stage 2 clears fraction digits past the 1e-6 stop point,
//   stage 3 finds the leading one, stage 4 normalizes into the output
//   register.
//   Reset clears all valid bits; the pipeline comes up empty and ready.
//   When the receiver stalls, the whole pipeline holds and s_tready drops
//   while the output register is full, so no item is lost or repeated.
module float_to_packed24_float (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [31:0] value_bits
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // [23:0] packed_word
	output logic        m_tuser   // [0] saturated
);
	logic ce;
	logic v_s1, v_s2, v_s3, v_s4;
	f2p24_pkg::stage_t st_in, st_s1, st_mask, st_s2, st_s3;
	logic [f2p24_pkg::POS_W-1:0] pos_in, pos_s3;
	logic nz_in, nz_s3;
	logic [f2p24_pkg::FRAC_W-1:0] frac_kept;
	logic [23:0] word_in, word_s4;
	logic sat_s4;

	assign ce = !v_s4 || m_tready;
	assign s_tready = ce;

	always_comb begin
		logic sign;
		logic [7:0] bexp;
		logic [23:0] m;
		logic [7:0] ex;
		logic [5:0] sh;
		sign = s_tdata[31];
		bexp = s_tdata[30:23];
		m = {1'b1, s_tdata[22:0]};
		ex = bexp - f2p24_pkg::BEXP_BIAS;
		sh = 6'(bexp - f2p24_pkg::BEXP_MIN);
		st_in.sign = sign;
		st_in.spec = 1'b1;
		st_in.sat = 1'b0;
		st_in.spec_word = '0;
		st_in.wide = '0;
		if (bexp == f2p24_pkg::BEXP_SPEC) begin
			st_in.spec_word = {sign & (s_tdata[22:0] == 23'd0), f2p24_pkg::EXP_MAX,
				f2p24_pkg::FRAC_ONES};
			st_in.sat = 1'b1;
		end else if (bexp >= f2p24_pkg::BEXP_BIG) begin
			if (ex > f2p24_pkg::EXP_LIMIT) begin
				st_in.spec_word = {sign, f2p24_pkg::EXP_MAX, m[23:8]};
				st_in.sat = 1'b1;
			end else begin
				st_in.spec_word = {sign, ex[6:0], m[23:8]};
			end
		end else if (bexp >= f2p24_pkg::BEXP_MIN) begin
			st_in.spec = 1'b0;
			st_in.wide = {{(f2p24_pkg::WIDE_W-24){1'b0}}, m} << sh;
		end
	end

	f2p24_mask u_mask (
		.frac     (st_s1.wide[f2p24_pkg::FRAC_W-1:0]),
		.frac_kept(frac_kept)
	);

	always_comb begin
		st_mask = st_s1;
		st_mask.wide = {st_s1.wide[f2p24_pkg::WIDE_W-1:f2p24_pkg::FRAC_W], frac_kept};
	end

	always_comb begin
		pos_in = '0;
		nz_in = 1'b0;
		for (int i = 0; i < f2p24_pkg::WIDE_W; i++) begin
			if (st_s2.wide[i]) begin
				pos_in = 7'(i);
				nz_in = 1'b1;
			end
		end
	end

	always_comb begin
		logic [f2p24_pkg::WIDE_W-1:0] norm;
		logic [6:0] ex;
		norm = st_s3.wide << (f2p24_pkg::POS_TOP - pos_s3);
		ex = pos_s3 + f2p24_pkg::EXP_OFFS;
		if (st_s3.spec) begin
			word_in = st_s3.spec_word;
		end else if (!nz_s3) begin
			word_in = '0;
		end else begin
			word_in = {st_s3.sign, ex, norm[f2p24_pkg::WIDE_W-1 -: 16]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (ce) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			st_s1 <= st_in;
			st_s2 <= st_mask;
			st_s3 <= st_s2;
			pos_s3 <= pos_in;
			nz_s3 <= nz_in;
			word_s4 <= word_in;
			sat_s4 <= st_s3.sat;
		end
	end

	assign m_tvalid = v_s4;
	assign m_tdata = word_s4;
	assign m_tuser = sat_s4;
endmodule

>>> hw/rtl/f2p24_mask.sv
// Fraction digit masking: clears every digit after the first point where
// the scaled remainder falls to 1e-6 or below. Depends on f2p24_pkg.
module f2p24_mask (
	input  logic [f2p24_pkg::FRAC_W-1:0] frac,
	output logic [f2p24_pkg::FRAC_W-1:0] frac_kept
);
	logic [f2p24_pkg::FRAC_W-1:0] ok;
	logic [f2p24_pkg::FRAC_W:0] run;

	always_comb begin
		for (int i = 0; i < f2p24_pkg::FRAC_W; i++) begin
			logic [f2p24_pkg::FRAC_W-1:0] low;
			logic [f2p24_pkg::FRAC_W-1:0] thr;
			low = {f2p24_pkg::FRAC_W{1'b1}} >> i;
			thr = {{(f2p24_pkg::FRAC_W-24){1'b0}}, f2p24_pkg::TINY_THR} >> i;
			ok[i] = (frac & low) > thr;
		end
		run[0] = 1'b1;
		for (int j = 1; j <= f2p24_pkg::FRAC_W; j++) begin
			run[j] = run[j-1] & ok[j-1];
		end
		for (int j = 1; j <= f2p24_pkg::FRAC_W; j++) begin
			frac_kept[f2p24_pkg::FRAC_W-j] = frac[f2p24_pkg::FRAC_W-j] & run[j];
		end
	end
endmodule

>>> hw/rtl/f2p24_checker.sv
// Port-level checker for float_to_packed24_float, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module f2p24_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic        m_tuser
);
	`CHK_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
	`CHK_IMPL(a_sat_exp, clk, arst_n, m_tvalid && m_tuser, m_tdata[22:16] == 7'd63)
	`CHK_IMPL(a_lead_one, clk, arst_n, m_tvalid && (m_tdata != 24'd0), m_tdata[15])
	`CHK_IMPL(a_ready_free, clk, arst_n, !m_tvalid, s_tready)
endmodule

bind float_to_packed24_float f2p24_checker u_f2p24_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);

>>> tb/tb_float_to_packed24_float.sv
// Testbench for float_to_packed24_float: IEEE single to packed 24-bit float words.
// A scoreboard class predicts each word and flag and checks results in order.
// Depends on the RTL only: float_to_packed24_float, f2p24_mask and f2p24_pkg.
module tb_float_to_packed24_float;
	timeunit 1ns;
	timeprecision 1ps;

	class conv_scoreboard;
		logic [24:0] pending[$];
		int errors;
		int checked;
		int sat_seen;

		function logic [24:0] convert(logic [31:0] bits);
			logic sign;
			logic [7:0] bexp;
			logic [23:0] m;
			int sh;
			int ex;
			int count;
			int k;
			logic [31:0] ip;
			logic [31:0] fi;
			logic [31:0] base;
			logic found;
			logic bitv;
			real r;
			sign = bits[31];
			bexp = bits[30:23];
			base = 0;
			count = 0;
			ex = 0;
			found = 0;
			k = 0;
			if (bexp == 8'hff)
				return {1'b1, (bits[22:0] != 0) ? 1'b0 : sign, 7'd63, 16'hffff};
			if (bexp >= 8'd150) begin
				ex = int'(bexp) - 126;
				m = {1'b1, bits[22:0]};
				if (ex > 63)
					return {1'b1, sign, 7'd63, m[23:8]};
				return {1'b0, sign, ex[6:0], m[23:8]};
			end
			m = (bexp != 0) ? {1'b1, bits[22:0]} : {1'b0, bits[22:0]};
			sh = (bexp != 0) ? 150 - int'(bexp) : 149;
			if (sh < 24) begin
				ip = 32'(m) >> sh;
				fi = 32'(m) & ((32'd1 << sh) - 1);
			end else begin
				ip = 0;
				fi = 32'(m);
			end
			r = real'(fi) * (2.0 ** (-sh));
			if (ip != 0) begin
				for (int n = 31; n >= 0; n--)
					if (ip[n] && !found) begin
						found = 1;
						ex = n + 1;
					end
				for (int i = ex - 1; i >= 0 && count < 16; i--) begin
					base = {base[30:0], ip[i]};
					count++;
				end
			end
			if (!found && !(r > 0.000001))
				return 25'd0;
			while (count < 16 && r > 0.000001) begin
				r = r * 2.0;
				bitv = (r >= 1.0);
				if (bitv)
					r = r - 1.0;
				if (!found && bitv) begin
					found = 1;
					ex = -k;
				end
				if (found) begin
					base = {base[30:0], bitv};
					count++;
				end
				k++;
			end
			base = base << (16 - count);
			return {1'b0, sign, ex[6:0], base[15:0]};
		endfunction

		function void note_input(logic [31:0] bits);
			pending.push_back(convert(bits));
		endfunction

		function void check_result(logic [23:0] word, logic sat);
			logic [24:0] exp_res;
			checked++;
			if (sat)
				sat_seen++;
			if (pending.size() == 0) begin
				$error("unexpected transfer: packed_word %h saturated %b", word, sat);
				errors++;
				return;
			end
			exp_res = pending.pop_front();
			if (exp_res[23:0] !== word) begin
				$error("packed_word expected %h actual %h", exp_res[23:0], word);
				errors++;
			end
			if (exp_res[24] !== sat) begin
				$error("saturated expected %b actual %b", exp_res[24], sat);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [31:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [23:0] m_tdata;
	logic m_tuser;

	conv_scoreboard sb = new();
	int idle_cycles = 0;
	int sent;
	bit timed_out = 0;

	float_to_packed24_float dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_input(s_tdata);
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata, m_tuser);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	always @(posedge clk) begin
		if (idle_cycles > 5000 && !timed_out) begin
			timed_out = 1;
			$display("tb_float_to_packed24_float NOT OK");
			$finish;
		end
	end

	// receiver: random stalls, stretches of full rate, one long hold
	initial begin
		int cyc;
		m_tready = 0;
		cyc = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc >= 400 && cyc < 700)
				m_tready <= 1'b0;
			else if ((cyc / 150) % 3 == 0)
				m_tready <= 1'b1;
			else
				m_tready <= ($urandom_range(0, 3) != 0);
		end
	end

	task automatic send(logic [31:0] v);
		s_tvalid <= 1'b1;
		s_tdata <= v;
		@(negedge clk);
		while (!s_tready)
			@(negedge clk);
		@(posedge clk);
		sent++;
	endtask

	task automatic pause(int n);
		s_tvalid <= 1'b0;
		s_tdata <= $urandom;
		repeat (n) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_value();
		logic [31:0] v;
		v = $urandom;
		case ($urandom_range(0, 9))
			0, 1: ;
			2: v[30:23] = 8'hff;
			3: v[30:23] = 8'd0;
			default: v[30:23] = 8'($urandom_range(100, 200));
		endcase
		return v;
	endfunction

	initial begin
		logic [31:0] directed[$];
		int burst;
		sent = 0;
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed = '{32'h00000000, 32'h80000000, 32'h00000001, 32'h807fffff,
			32'h358637bd, 32'h358637be, 32'hb58637be, 32'h3f800000, 32'hbfc00000,
			32'h3dcccccd, 32'h3727c5ac, 32'h40400000, 32'h4b000000, 32'h4b7fffff,
			32'hcb800000, 32'h5e800000, 32'h5f000000, 32'hdf000000, 32'h7f7fffff,
			32'h7f800000, 32'hff800000, 32'h7fc00000, 32'hffc00000, 32'hff800001,
			32'h3f7fffff};
		foreach (directed[i])
			send(directed[i]);
		while (sent < 750) begin
			burst = $urandom_range(1, 40);
			repeat (burst)
				send(rand_value());
			if ($urandom_range(0, 3) != 0)
				pause($urandom_range(1, 6));
		end
		s_tvalid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		$display("Converted %0d values: zeros, subnormals, 1e-6 edge, integers, overflow,",
			sent);
		$display("infinities and NaNs; %0d results checked, %0d saturated.",
			sb.checked, sb.sat_seen);
		if (sb.errors == 0)
			$display("tb_float_to_packed24_float OK");
		else
			$display("tb_float_to_packed24_float NOT OK");
		$finish;
	end
endmodule
